@@ sv/lprd_pkg.sv @@
`timescale 1ns / 1ps
package lprd_pkg;

  // header layout: 16-bit length, then 16-bit function id
  localparam int unsigned LPRD_HEADER_BYTES = 2 + 2;
  localparam logic [15:0] LPRD_ID_BYTES     = 16'd2;

  // default depth of the queue between parser and output stage
  localparam int unsigned LPRD_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_LEN_A,
    PH_LEN_B,
    PH_ID_A,
    PH_ID_B,
    PH_DATA,
    PH_HALT
  } lprd_phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_FORMAT = 2'd2
  } lprd_kind_t;

  // one classified result on its way to the output stage
  typedef struct packed {
    lprd_kind_t  kind;
    logic [15:0] function_id;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        last_of_record;
  } lprd_entry_t;

  // queue status seen by the parser and the output stage
  typedef struct packed {
    logic full;
    logic empty;
  } lprd_qstat_t;

endpackage

@@ sv/lprd_front.sv @@
`timescale 1ns / 1ps
module lprd_front
  import lprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  input  logic        cfg_valid,
  input  logic        cfg_big_endian_fields,
  output logic        cfg_ready,
  input  lprd_qstat_t qstat_i,
  output logic        push_o,
  output lprd_entry_t entry_o
);

  lprd_phase_t phase_r, phase_nxt;
  logic        big_endian_r;
  logic [7:0]  first_byte_r, first_byte_nxt;
  logic [15:0] rec_len_r, rec_len_nxt;
  logic [15:0] func_id_r, func_id_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] left_r, left_nxt;
  logic        accept;
  logic [15:0] joined;
  logic        last_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat_i.full;
  assign accept    = in_valid && !qstat_i.full;

  // 16-bit field assembled at its second byte with the current byte order
  assign joined    = big_endian_r ? {first_byte_r, in_rx_byte} : {in_rx_byte, first_byte_r};
  assign last_byte = (left_r <= 16'd1);

  // byte order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      big_endian_r <= cfg_big_endian_fields;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN_A;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // held header fields and payload counter
  always_ff @(posedge clk) begin
    first_byte_r <= first_byte_nxt;
    rec_len_r    <= rec_len_nxt;
    func_id_r    <= func_id_nxt;
    plen_r       <= plen_nxt;
    left_r       <= left_nxt;
  end

  // classify each accepted byte
  always_comb begin
    phase_nxt      = phase_r;
    first_byte_nxt = first_byte_r;
    rec_len_nxt    = rec_len_r;
    func_id_nxt    = func_id_r;
    plen_nxt       = plen_r;
    left_nxt       = left_r;
    push_o         = 1'b0;
    entry_o        = '{kind: KIND_DATA, function_id: func_id_r, payload_byte: 8'd0,
                       payload_length: 16'd0, last_of_record: 1'b1};
    if (accept) begin
      case (phase_r)
        PH_LEN_A: begin
          first_byte_nxt = in_rx_byte;
          phase_nxt      = PH_LEN_B;
        end
        PH_LEN_B: begin
          rec_len_nxt = joined;
          phase_nxt   = PH_ID_A;
        end
        PH_ID_A: begin
          first_byte_nxt = in_rx_byte;
          phase_nxt      = PH_ID_B;
        end
        PH_ID_B: begin
          func_id_nxt         = joined;
          entry_o.function_id = joined;
          if (rec_len_r < LPRD_ID_BYTES) begin
            phase_nxt    = PH_HALT;
            push_o       = 1'b1;
            entry_o.kind = KIND_FORMAT;
          end else if (rec_len_r == LPRD_ID_BYTES) begin
            phase_nxt    = PH_LEN_A;
            push_o       = 1'b1;
            entry_o.kind = KIND_EMPTY;
          end else begin
            plen_nxt  = rec_len_r - LPRD_ID_BYTES;
            left_nxt  = rec_len_r - LPRD_ID_BYTES;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          push_o                 = 1'b1;
          entry_o.kind           = KIND_DATA;
          entry_o.payload_byte   = in_rx_byte;
          entry_o.payload_length = plen_r;
          entry_o.last_of_record = last_byte;
          if (last_byte) begin
            left_nxt  = 16'd0;
            phase_nxt = PH_LEN_A;
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
        default: begin
          // halted after a format error: bytes are dropped
          phase_nxt = phase_r;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |-> !qstat_i.full)
    else $error("parser pushed into a full queue");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |=> (phase_r == PH_HALT))
    else $error("parser left the halted state without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |-> !push_o)
    else $error("result produced after a format error");
`endif

endmodule

@@ sv/lprd_queue.sv @@
`timescale 1ns / 1ps
module lprd_queue
  import lprd_pkg::*;
#(
  parameter int unsigned DEPTH = LPRD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_i,
  input  lprd_entry_t entry_i,
  input  logic        pop_i,
  output lprd_entry_t entry_o,
  output lprd_qstat_t qstat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lprd_entry_t      slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign qstat_o.full  = (count_r == CW'(DEPTH));
  assign qstat_o.empty = (count_r == '0);
  assign entry_o       = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("pop from an empty queue");
`endif

endmodule

@@ sv/lprd_back.sv @@
`timescale 1ns / 1ps
module lprd_back
  import lprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lprd_qstat_t qstat_i,
  input  lprd_entry_t entry_i,
  output logic        pop_o,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_function_id,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_length,
  output logic        out_last_of_record
);

  logic        out_valid_r;
  lprd_entry_t out_entry_r;

  // refill the output register when it is empty or being taken
  assign pop_o = !qstat_i.empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_o) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      out_entry_r <= entry_i;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_entry_r.kind;
  assign out_function_id    = out_entry_r.function_id;
  assign out_payload_byte   = out_entry_r.payload_byte;
  assign out_payload_length = out_entry_r.payload_length;
  assign out_last_of_record = out_entry_r.last_of_record;

endmodule

@@ sv/length_prefixed_record_deframer_top.sv @@
`timescale 1ns / 1ps
// Length-prefixed record deframer.
// Input channel (in_valid / in_stall / in_rx_byte) takes one stream byte per
// transaction. Records are a 16-bit length, a 16-bit function id and
// (length - 2) payload bytes. The result channel (out_valid / out_stall)
// gives one transaction per payload byte, one per empty record, and one
// format-error transaction when a length below 2 is seen; after that error
// input bytes are accepted and dropped until reset.
// cfg_valid / cfg_ready write the byte-order bit (0 low byte first); cfg_ready
// is always high.
// Throughput: one byte per cycle while the queue is not full. A result passes
// from the parser into the queue, then from the queue into the output register,
// before it shows on out_valid.
// When the receiver stalls, the output register holds and the queue between
// parser and output stage (QUEUE_DEPTH entries) fills; in_stall rises once it
// is full. Header bytes that produce no result are still held off while the
// queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid, returns
// the parser to the first length byte and clears the byte-order bit.
module length_prefixed_record_deframer_top
  import lprd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = LPRD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_big_endian_fields,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_function_id,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_length,
  output logic        out_last_of_record
);

  lprd_qstat_t qstat;
  lprd_entry_t push_entry;
  lprd_entry_t head_entry;
  logic        push;
  logic        pop;

  // parser: header tracking and classification
  lprd_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_rx_byte            (in_rx_byte),
    .in_stall              (in_stall),
    .cfg_valid             (cfg_valid),
    .cfg_big_endian_fields (cfg_big_endian_fields),
    .cfg_ready             (cfg_ready),
    .qstat_i               (qstat),
    .push_o                (push),
    .entry_o               (push_entry)
  );

  // decoupling queue
  lprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  // output stage
  lprd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .qstat_i            (qstat),
    .entry_i            (head_entry),
    .pop_o              (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_function_id    (out_function_id),
    .out_payload_byte   (out_payload_byte),
    .out_payload_length (out_payload_length),
    .out_last_of_record (out_last_of_record)
  );

endmodule

@@ verif/length_prefixed_record_deframer_top_tb.sv @@
`timescale 1ns / 1ps
module length_prefixed_record_deframer_top_tb;
  import lprd_pkg::*;

  localparam int unsigned IDLE_PCT      = 9;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 12;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_ORDER
  } stim_op_t;

  typedef struct packed {
    stim_op_t   op;
    logic [7:0] value;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_big_endian_fields = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [15:0] out_function_id;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_length;
  logic        out_last_of_record;

  // stimulus stream and byte order used while building it
  stim_t       stream_q[$];
  logic        gen_big_endian = 1'b0;

  // deframer state tracked alongside the block
  lprd_phase_t parse_ph;
  logic [15:0] rec_len;
  logic [15:0] rec_id;
  logic [15:0] bytes_left;
  logic [7:0]  field_first;
  logic        be_fields;
  lprd_entry_t awaited_results[$];

  logic        byte_taken = 1'b0;
  logic        order_taken = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settle_count = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  length_prefixed_record_deframer_top uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_big_endian_fields (cfg_big_endian_fields),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_kind       (out_result_kind),
    .out_function_id       (out_function_id),
    .out_payload_byte      (out_payload_byte),
    .out_payload_length    (out_payload_length),
    .out_last_of_record    (out_last_of_record)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // stimulus building
  task automatic push_byte(input logic [7:0] v);
    stream_q.push_back('{op: STIM_BYTE, value: v});
  endtask

  task automatic push_field(input logic [15:0] v);
    if (gen_big_endian) begin
      push_byte(v[15:8]);
      push_byte(v[7:0]);
    end else begin
      push_byte(v[7:0]);
      push_byte(v[15:8]);
    end
  endtask

  task automatic push_order(input logic v);
    stream_q.push_back('{op: STIM_ORDER, value: {7'd0, v}});
    gen_big_endian = v;
  endtask

  task automatic push_record(input logic [15:0] len, input logic [15:0] id);
    int unsigned k;
    push_field(len);
    push_field(id);
    if (len > LPRD_ID_BYTES) begin
      for (k = 0; k < int'(len) - 2; k++) push_byte(8'($urandom_range(255, 0)));
    end
  endtask

  // joins a 16-bit header field at its second byte
  function automatic logic [15:0] join_field(input logic [7:0] second);
    return be_fields ? {field_first, second} : {second, field_first};
  endfunction

  // advance the deframer by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    lprd_entry_t e;
    e = '0;
    case (parse_ph)
      PH_LEN_A: begin
        field_first = b;
        parse_ph = PH_LEN_B;
      end
      PH_LEN_B: begin
        rec_len = join_field(b);
        parse_ph = PH_ID_A;
      end
      PH_ID_A: begin
        field_first = b;
        parse_ph = PH_ID_B;
      end
      PH_ID_B: begin
        rec_id = join_field(b);
        e.function_id = rec_id;
        e.last_of_record = 1'b1;
        if (rec_len < LPRD_ID_BYTES) begin
          // bad length: one error transaction, then input is dropped
          parse_ph = PH_HALT;
          e.kind = KIND_FORMAT;
          awaited_results.push_back(e);
        end else if (rec_len == LPRD_ID_BYTES) begin
          parse_ph = PH_LEN_A;
          e.kind = KIND_EMPTY;
          awaited_results.push_back(e);
        end else begin
          bytes_left = rec_len - LPRD_ID_BYTES;
          parse_ph = PH_DATA;
        end
      end
      PH_DATA: begin
        e.kind = KIND_DATA;
        e.function_id = rec_id;
        e.payload_byte = b;
        e.payload_length = rec_len - LPRD_ID_BYTES;
        e.last_of_record = (bytes_left <= 16'd1);
        if (e.last_of_record) begin
          bytes_left = 16'd0;
          parse_ph = PH_LEN_A;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
        awaited_results.push_back(e);
      end
      default: ;
    endcase
  endtask

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    lprd_entry_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result transaction: kind %0d id %h", out_result_kind,
             out_function_id);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("result_kind", 16'(want.kind), 16'(out_result_kind));
      compare_field("function_id", want.function_id, out_function_id);
      compare_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
      compare_field("payload_length", want.payload_length, out_payload_length);
      compare_field("last_of_record", 16'(want.last_of_record), 16'(out_last_of_record));
    end
  endtask

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    byte_taken  <= in_valid && !in_stall;
    order_taken <= cfg_valid && cfg_ready;
    if (!rst_n) begin
      parse_ph    = PH_LEN_A;
      rec_len     = 16'd0;
      rec_id      = 16'd0;
      bytes_left  = 16'd0;
      field_first = 8'd0;
      be_fields   = 1'b0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        results_seen++;
        check_result();
      end
      if (cfg_valid && cfg_ready) be_fields = cfg_big_endian_fields;
    end
  end

  // sender: byte transactions and register writes once the block is idle
  always @(negedge clk) begin
    logic       next_valid;
    logic [7:0] next_byte;
    logic       next_cfg_valid;
    logic       next_cfg_data;
    logic       quiet;
    next_valid     = in_valid;
    next_byte      = in_rx_byte;
    next_cfg_valid = cfg_valid;
    next_cfg_data  = cfg_big_endian_fields;
    quiet          = (bytes_sent >= 500) && (bytes_sent < 900);
    if (rst_n) begin
      if (in_valid && byte_taken) begin
        next_valid = 1'b0;
        bytes_sent++;
      end
      if (cfg_valid && order_taken) next_cfg_valid = 1'b0;
      if (!next_valid && !next_cfg_valid && stream_q.size() != 0) begin
        case (stream_q[0].op)
          STIM_BYTE: begin
            if (quiet || $urandom_range(99, 0) >= IDLE_PCT) begin
              next_valid = 1'b1;
              next_byte  = stream_q[0].value;
              void'(stream_q.pop_front());
            end
          end
          STIM_ORDER: begin
            // wait for every result, then let the pipeline settle
            if (awaited_results.size() != 0) begin
              settle_count = 0;
            end else if (settle_count < SETTLE_CYCLES) begin
              settle_count++;
            end else begin
              settle_count   = 0;
              next_cfg_valid = 1'b1;
              next_cfg_data  = stream_q[0].value[0];
              void'(stream_q.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    in_valid              <= next_valid;
    in_rx_byte            <= next_byte;
    cfg_valid             <= next_cfg_valid;
    cfg_big_endian_fields <= next_cfg_data;
  end

  // receiver: random stalls, a quiet stretch and long hold-offs
  always @(negedge clk) begin
    logic next_stall;
    logic quiet;
    next_stall = 1'b0;
    quiet      = (results_seen >= 400) && (results_seen < 700);
    if (hold_left != 0) begin
      next_stall = 1'b1;
      hold_left--;
    end else if (holds_done < 2 && results_seen >= 250 + holds_done * 550 && in_valid) begin
      next_stall = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      holds_done++;
    end else if (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
      next_stall = 1'b1;
    end
    out_stall <= next_stall;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_bytes;
    int unsigned roll;
    int unsigned k;
    logic [15:0] len;

    // directed: empty record, byte extremes, both byte orders
    push_field(16'd2);
    push_field(16'hFFFF);
    push_field(16'd3);
    push_field(16'h0000);
    push_byte(8'h00);
    push_field(16'd4);
    push_field(16'hA55A);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_order(1'b1);
    push_field(16'd3);
    push_field(16'h1234);
    push_byte(8'h7F);
    // order flips between the two bytes of the length and of the id
    push_byte(8'h03);
    push_order(1'b0);
    push_byte(8'h00);
    push_byte(8'h34);
    push_order(1'b1);
    push_byte(8'h12);
    push_byte(8'hC3);

    // random records in phases, byte order rewritten between phases
    for (phase = 0; phase < 8; phase++) begin
      push_order(phase == 0 ? 1'b0 : 1'($urandom_range(1, 0)));
      phase_bytes = 0;
      while (phase_bytes < 85) begin
        roll = $urandom_range(99, 0);
        if (roll < 15) len = 16'd2;
        else if (roll < 92) len = 16'($urandom_range(20, 3));
        else len = 16'($urandom_range(300, 21));
        push_record(len, 16'($urandom));
        phase_bytes += 2 + len;
      end
    end

    // one long record with a nonzero upper length byte
    push_order(1'($urandom_range(1, 0)));
    push_record(16'($urandom_range(400, 256)), 16'($urandom));

    // bad length ends parsing; the trailing bytes are dropped
    push_record(16'($urandom_range(1, 0)), 16'($urandom));
    for (k = 0; k < 20; k++) push_byte(8'($urandom_range(255, 0)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_valid || cfg_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lprd_pkg.sv
sv/lprd_front.sv
sv/lprd_queue.sv
sv/lprd_back.sv
sv/length_prefixed_record_deframer_top.sv
verif/length_prefixed_record_deframer_top_tb.sv
